// ===== design/lcpr_pkg.sv =====
// ----------------------------------------------------------------------------
// lcpr_pkg
// Types and constants shared by the length/checksum packet receiver.
// ----------------------------------------------------------------------------
package lcpr_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned MOD_W   = 2;
    localparam int unsigned CIDX_W  = 2;

    localparam logic [BYTE_W-1:0] ACK_CHECKSUM = 8'hCC;
    localparam logic [BYTE_W-1:0] MODULE_MASK  = 8'hC0;

    localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
    localparam logic [STAT_W-1:0] ST_CHECKSUM    = 3'd1;
    localparam logic [STAT_W-1:0] ST_LENGTH      = 3'd2;
    localparam logic [STAT_W-1:0] ST_ERROR_REPLY = 3'd3;
    localparam logic [STAT_W-1:0] ST_MISMATCH    = 3'd4;

    localparam logic [CIDX_W-1:0] CFG_EXPECTED_CMD = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_CHECK_CMD    = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_ERROR_CMD    = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] expected_command;
        logic              check_command;
        logic [BYTE_W-1:0] error_command;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              payload_valid;
        logic              frame_end;
        logic [STAT_W-1:0] status;
        logic [BYTE_W-1:0] frame_command;
        logic [MOD_W-1:0]  command_module;
    } t_result;

endpackage

// ===== design/lcpr_if.sv =====
// ----------------------------------------------------------------------------
// lcpr channel interfaces
// Receive byte channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface lcpr_rx_if;
    logic                       valid;
    logic                       ready;
    logic [lcpr_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lcpr_res_if;
    logic                        valid;
    logic                        ready;
    logic [lcpr_pkg::BYTE_W-1:0] payload_byte;
    logic                        payload_valid;
    logic                        frame_end;
    logic [lcpr_pkg::STAT_W-1:0] status;
    logic [lcpr_pkg::BYTE_W-1:0] frame_command;
    logic [lcpr_pkg::MOD_W-1:0]  command_module;

    modport source (output valid, output payload_byte, output payload_valid,
                    output frame_end, output status, output frame_command,
                    output command_module, input ready);
    modport sink   (input valid, input payload_byte, input payload_valid,
                    input frame_end, input status, input frame_command,
                    input command_module, output ready);
endinterface

interface lcpr_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [lcpr_pkg::CIDX_W-1:0] index;
    logic [lcpr_pkg::BYTE_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/length_checksum_packet_receiver.sv =====
// ----------------------------------------------------------------------------
// length_checksum_packet_receiver
// Splits a received byte stream into length/checksum frames.
// ----------------------------------------------------------------------------
// Channels: i_rx takes one received byte per item. o_res gives a result for
// every payload byte after the command and one on the last byte of each
// frame, carrying frame_end and status. Header bytes and a command byte
// that are not the last of their frame give no result. i_cfg writes the
// three registers (0 expected command, 1 check enable, 2 error command);
// it is always ready and should be written only while the block is idle.
// Path: an accepted byte is held in the input register; its result is then
// loaded into the result register, which drives o_res.
// Throughput: one byte per cycle while o_res is not held, set by the frame
// state update between the two registers.
// Reset: both registers empty, frame state waits for a length byte and all
// configuration registers read zero.
// Stall: while o_res is held, the result register keeps its item; one more
// byte waits in the input register, after which i_rx.ready drops.
// ----------------------------------------------------------------------------
module length_checksum_packet_receiver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lcpr_rx_if.sink    i_rx,
    lcpr_cfg_if.sink   i_cfg,
    lcpr_res_if.source o_res
);
    import lcpr_pkg::*;

    t_cfg              r_cfg;
    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              out_free;
    logic              advance;
    logic              has_result;
    t_result           result;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_EXPECTED_CMD: r_cfg.expected_command <= i_cfg.data;
                CFG_CHECK_CMD:    r_cfg.check_command    <= i_cfg.data[0];
                CFG_ERROR_CMD:    r_cfg.error_command    <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    assign advance = in_valid && out_free;

    lcpr_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    lcpr_deframer u_deframer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_byte       (in_byte),
        .i_cfg        (r_cfg),
        .o_has_result (has_result),
        .o_result     (result)
    );

    lcpr_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (advance),
        .i_has_result (has_result),
        .i_result     (result),
        .o_free       (out_free),
        .o_res        (o_res)
    );
endmodule

// ===== design/lcpr_in_stage.sv =====
// ----------------------------------------------------------------------------
// lcpr_in_stage
// Input register for received bytes; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module lcpr_in_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    lcpr_rx_if.sink                     i_rx,
    input  logic                        i_advance,
    output logic                        o_valid,
    output logic [lcpr_pkg::BYTE_W-1:0] o_byte
);
    import lcpr_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;

    assign i_rx.ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
endmodule

// ===== design/lcpr_deframer.sv =====
// ----------------------------------------------------------------------------
// lcpr_deframer
// Frame state, running checksum and status decision for one byte.
// ----------------------------------------------------------------------------
module lcpr_deframer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [lcpr_pkg::BYTE_W-1:0] i_byte,
    input  lcpr_pkg::t_cfg              i_cfg,
    output logic                        o_has_result,
    output lcpr_pkg::t_result           o_result
);
    import lcpr_pkg::*;

    logic [BYTE_W-1:0] r_pos, n_pos;
    logic [BYTE_W-1:0] r_len, n_len;
    logic [BYTE_W-1:0] r_chk, n_chk;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic [BYTE_W-1:0] r_cmd, n_cmd;

    logic              is_cmd;
    logic              is_last;
    logic [STAT_W-1:0] data_status;
    logic [BYTE_W-1:0] res_cmd;
    logic [BYTE_W-1:0] res_pay;
    logic              res_pay_ok;
    logic              res_end;
    logic [STAT_W-1:0] res_status;

    assign is_cmd  = (r_pos == 8'd2);
    assign is_last = ({1'b0, r_pos} + 9'd1) >= {1'b0, r_len};

    always_comb begin
        if (n_sum != r_chk) begin
            data_status = ST_CHECKSUM;
        end else if (i_cfg.check_command && (n_cmd == i_cfg.error_command)) begin
            data_status = ST_ERROR_REPLY;
        end else if (i_cfg.check_command && (n_cmd != i_cfg.expected_command)) begin
            data_status = ST_MISMATCH;
        end else begin
            data_status = ST_OK;
        end
    end

    always_comb begin
        n_pos        = r_pos;
        n_len        = r_len;
        n_chk        = r_chk;
        n_sum        = r_sum;
        n_cmd        = r_cmd;
        o_has_result = 1'b0;
        res_pay      = '0;
        res_pay_ok   = 1'b0;
        res_end      = 1'b0;
        res_status   = ST_OK;
        res_cmd      = '0;
        case (r_pos)
            8'd0: begin
                n_len = i_byte;
                n_sum = '0;
                n_cmd = '0;
                n_chk = '0;
                if (i_byte == 8'd1) begin
                    o_has_result = 1'b1;
                    res_end      = 1'b1;
                    res_status   = ST_LENGTH;
                end else begin
                    n_pos = 8'd1;
                end
            end
            8'd1: begin
                n_chk = i_byte;
                if (r_len == 8'd0) begin
                    n_pos        = '0;
                    o_has_result = 1'b1;
                    res_end      = 1'b1;
                    res_status   = (i_byte == ACK_CHECKSUM) ? ST_OK : ST_CHECKSUM;
                end else if (r_len == 8'd2) begin
                    n_pos        = '0;
                    o_has_result = 1'b1;
                    res_end      = 1'b1;
                    res_status   = (i_byte == 8'd0) ? ST_OK : ST_CHECKSUM;
                end else begin
                    n_pos = 8'd2;
                end
            end
            default: begin
                n_sum = r_sum + i_byte;
                n_cmd = is_cmd ? i_byte : r_cmd;
                res_cmd = n_cmd;
                if (is_last) begin
                    n_pos        = '0;
                    o_has_result = 1'b1;
                    res_pay      = is_cmd ? '0 : i_byte;
                    res_pay_ok   = !is_cmd;
                    res_end      = 1'b1;
                    res_status   = data_status;
                end else begin
                    n_pos        = r_pos + 8'd1;
                    o_has_result = !is_cmd;
                    res_pay      = i_byte;
                    res_pay_ok   = !is_cmd;
                end
            end
        endcase
    end

    assign o_result.payload_byte   = res_pay;
    assign o_result.payload_valid  = res_pay_ok;
    assign o_result.frame_end      = res_end;
    assign o_result.status         = res_status;
    assign o_result.frame_command  = res_cmd;
    assign o_result.command_module = MOD_W'((res_cmd & MODULE_MASK) >> (BYTE_W - MOD_W));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_len <= '0;
            r_chk <= '0;
            r_sum <= '0;
            r_cmd <= '0;
        end else if (i_step) begin
            r_pos <= n_pos;
            r_len <= n_len;
            r_chk <= n_chk;
            r_sum <= n_sum;
            r_cmd <= n_cmd;
        end
    end
endmodule

// ===== design/lcpr_out_stage.sv =====
// ----------------------------------------------------------------------------
// lcpr_out_stage
// Result register driving the result channel.
// ----------------------------------------------------------------------------
module lcpr_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_has_result,
    input  lcpr_pkg::t_result i_result,
    output logic              o_free,
    lcpr_res_if.source        o_res
);
    import lcpr_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load && i_has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_has_result) begin
            r_result <= i_result;
        end
    end

    assign o_res.valid          = r_valid;
    assign o_res.payload_byte   = r_result.payload_byte;
    assign o_res.payload_valid  = r_result.payload_valid;
    assign o_res.frame_end      = r_result.frame_end;
    assign o_res.status         = r_result.status;
    assign o_res.frame_command  = r_result.frame_command;
    assign o_res.command_module = r_result.command_module;
endmodule

// ===== design/lcpr_checker.sv =====
// ----------------------------------------------------------------------------
// lcpr_checker
// Port-level checks on the result channel of the packet receiver.
// ----------------------------------------------------------------------------
module lcpr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_rx_valid,
    input logic                        i_rx_ready,
    input logic                        i_res_valid,
    input logic                        i_res_ready,
    input logic [lcpr_pkg::BYTE_W-1:0] i_payload_byte,
    input logic                        i_payload_valid,
    input logic                        i_frame_end,
    input logic [lcpr_pkg::STAT_W-1:0] i_status,
    input logic [lcpr_pkg::BYTE_W-1:0] i_frame_command,
    input logic [lcpr_pkg::MOD_W-1:0]  i_command_module
);
    import lcpr_pkg::*;

    a_status_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_frame_end) |-> (i_status == ST_OK))
        else $error("status set on a non-final item");

    a_item_carries_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_payload_valid || i_frame_end))
        else $error("result item with neither payload nor frame end");

    a_module_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_command_module == i_frame_command[BYTE_W-1 -: MOD_W]))
        else $error("command_module does not match frame_command");

    a_no_result_from_nothing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_res_valid && !$past(i_rx_valid && i_rx_ready)) |=> !i_res_valid)
        else $error("result appeared with no byte in flight");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_payload_byte)))
        else $error("stalled result dropped or changed");

endmodule

bind length_checksum_packet_receiver lcpr_checker u_lcpr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_rx_valid       (i_rx.valid),
    .i_rx_ready       (i_rx.ready),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_payload_byte   (o_res.payload_byte),
    .i_payload_valid  (o_res.payload_valid),
    .i_frame_end      (o_res.frame_end),
    .i_status         (o_res.status),
    .i_frame_command  (o_res.frame_command),
    .i_command_module (o_res.command_module)
);

// ===== verif/length_checksum_packet_receiver_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// length_checksum_packet_receiver_test
// Drives framed byte streams into the receiver and checks every result item
// against a frame-state predictor kept in step with each accepted byte. A
// short directed table covers the header cases and extreme bytes; random
// frames then run under several register settings and idling patterns.
// ----------------------------------------------------------------------------
module length_checksum_packet_receiver_test;
    import lcpr_pkg::*;

    localparam int IDLE_LIMIT      = 2000;
    localparam int TAIL_CYCLES     = 4;
    localparam int ITEMS_PER_PHASE = 185;
    localparam int N_PHASES        = 8;
    localparam int N_DIRECTED      = 24;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              typed;
        t_result           result;
    } t_stim_row;

    localparam t_result END_OK       = '{8'h00, 1'b0, 1'b1, ST_OK, 8'h00, 2'd0};
    localparam t_result END_CHECKSUM = '{8'h00, 1'b0, 1'b1, ST_CHECKSUM, 8'h00, 2'd0};
    localparam t_result END_LENGTH   = '{8'h00, 1'b0, 1'b1, ST_LENGTH, 8'h00, 2'd0};

    localparam t_stim_row DIRECTED_STIM [N_DIRECTED] = '{
        '{8'h01, 1'b1, END_LENGTH},     // lone length byte of one
        '{8'h00, 1'b0, '0},             // ack, good checksum
        '{8'hCC, 1'b1, END_OK},
        '{8'h00, 1'b0, '0},             // ack, bad checksum
        '{8'h33, 1'b1, END_CHECKSUM},
        '{8'h02, 1'b0, '0},             // empty frame, zero checksum
        '{8'h00, 1'b1, END_OK},
        '{8'h02, 1'b0, '0},             // empty frame, bad checksum
        '{8'hFF, 1'b1, END_CHECKSUM},
        '{8'h03, 1'b0, '0},             // command only, top module bits
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h05, 1'b0, '0},
        '{8'h81, 1'b0, '0},
        '{8'h80, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h04, 1'b0, '0},             // sum wraps to zero
        '{8'h00, 1'b0, '0},
        '{8'h40, 1'b0, '0},
        '{8'hC0, 1'b0, '0},
        '{8'h03, 1'b0, '0},             // bad checksum, command only
        '{8'h12, 1'b0, '0},
        '{8'h34, 1'b0, '0}
    };

    localparam t_cfg PHASE_CFG [N_PHASES] = '{
        '{8'h00, 1'b0, 8'h00},
        '{8'hA5, 1'b1, 8'h5A},
        '{8'hFF, 1'b1, 8'h00},
        '{8'h00, 1'b1, 8'hFF},
        '{8'h3C, 1'b1, 8'h3C},
        '{8'h81, 1'b0, 8'h7E},
        '{8'hFF, 1'b1, 8'hFF},
        '{8'h42, 1'b1, 8'hC3}
    };

    logic i_clk;
    logic i_rst_n     = 1'b0;
    logic take_result = 1'b0;

    lcpr_rx_if  rx_ch ();
    lcpr_cfg_if cfg_ch ();
    lcpr_res_if res_ch ();

    assign res_ch.ready = take_result;

    length_checksum_packet_receiver dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    // frame state mirror and register copy
    logic [BYTE_W-1:0] fr_pos, fr_len, fr_chk, fr_sum, fr_cmd;
    t_cfg              regs;

    t_result pending_results [$];
    int      gap_pct     = 0;
    int      stall_pct   = 0;
    int      items_sent  = 0;
    int      failures    = 0;
    int      idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [STAT_W-1:0] frame_verdict();
        if (fr_sum != fr_chk)
            return ST_CHECKSUM;
        if (regs.check_command) begin
            if (fr_cmd == regs.error_command)
                return ST_ERROR_REPLY;
            if (fr_cmd != regs.expected_command)
                return ST_MISMATCH;
        end
        return ST_OK;
    endfunction

    task automatic frame_step(input logic [BYTE_W-1:0] b, output bit got, output t_result r);
        bit is_cmd;
        bit last;
        got = 1'b0;
        r   = '0;
        if (fr_pos == 0) begin
            fr_len = b;
            fr_sum = '0;
            fr_cmd = '0;
            fr_chk = '0;
            if (b == 8'd1) begin
                got         = 1'b1;
                r.frame_end = 1'b1;
                r.status    = ST_LENGTH;
            end else begin
                fr_pos = 8'd1;
            end
        end else if (fr_pos == 1) begin
            fr_chk = b;
            if (fr_len == 0 || fr_len == 2) begin
                fr_pos      = '0;
                got         = 1'b1;
                r.frame_end = 1'b1;
                r.status    = (b == ((fr_len == 0) ? ACK_CHECKSUM : 8'h00)) ? ST_OK : ST_CHECKSUM;
            end else begin
                fr_pos = 8'd2;
            end
        end else begin
            fr_sum = fr_sum + b;
            is_cmd = (fr_pos == 2);
            last   = (fr_pos + 1 >= fr_len);
            if (is_cmd)
                fr_cmd = b;
            r.frame_command  = fr_cmd;
            r.command_module = fr_cmd[BYTE_W-1 -: MOD_W];
            if (!is_cmd) begin
                r.payload_valid = 1'b1;
                r.payload_byte  = b;
            end
            if (last) begin
                fr_pos      = '0;
                got         = 1'b1;
                r.frame_end = 1'b1;
                r.status    = frame_verdict();
            end else begin
                fr_pos = fr_pos + 1;
                got    = !is_cmd;
            end
        end
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed, input t_result typed_res);
        bit      got;
        t_result r;
        while ($urandom_range(0, 99) < gap_pct) begin
            rx_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (!rx_ch.ready);
        items_sent++;
        frame_step(b, got, r);
        if (typed)
            pending_results.push_back(typed_res);
        else if (got)
            pending_results.push_back(r);
    endtask

    task automatic finish_frame();
        while (fr_pos != 0)
            send_byte(8'($urandom), 1'b0, '0);
    endtask

    task automatic send_frame();
        int unsigned       pick;
        int unsigned       len;
        int unsigned       cmd_pick;
        logic [BYTE_W-1:0] body [$];
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] chk;
        logic [BYTE_W-1:0] cmd;
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            // stray bytes, then resync on a frame boundary
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom), 1'b0, '0);
            finish_frame();
            return;
        end
        if (pick < 8) begin
            send_byte(8'h00, 1'b0, '0);
            send_byte($urandom_range(0, 1) ? ACK_CHECKSUM : 8'($urandom), 1'b0, '0);
            return;
        end
        if (pick < 12) begin
            send_byte(8'h01, 1'b0, '0);
            return;
        end
        if (pick < 17) begin
            send_byte(8'h02, 1'b0, '0);
            send_byte($urandom_range(0, 1) ? 8'h00 : 8'($urandom), 1'b0, '0);
            return;
        end
        if (pick < 19)
            len = $urandom_range(200, 255);
        else if (pick < 29)
            len = $urandom_range(11, 40);
        else
            len = $urandom_range(3, 10);
        cmd      = 8'($urandom);
        cmd_pick = $urandom_range(0, 99);
        if (regs.check_command && cmd_pick < 40)
            cmd = regs.expected_command;
        else if (regs.check_command && cmd_pick < 65)
            cmd = regs.error_command;
        body.push_back(cmd);
        sum = cmd;
        repeat (len - 3) begin
            body.push_back(8'($urandom));
            sum = sum + body[$];
        end
        chk = ($urandom_range(0, 99) < 15) ? sum + 8'($urandom_range(1, 255)) : sum;
        send_byte(8'(len), 1'b0, '0);
        send_byte(chk, 1'b0, '0);
        foreach (body[i])
            send_byte(body[i], 1'b0, '0);
    endtask

    task automatic reg_write(input logic [CIDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_EXPECTED_CMD: regs.expected_command = val;
            CFG_CHECK_CMD:    regs.check_command    = val[0];
            CFG_ERROR_CMD:    regs.error_command    = val;
            default: ;
        endcase
    endtask

    task automatic settle();
        rx_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_result();
        t_result want;
        t_result seen;
        seen.payload_byte   = res_ch.payload_byte;
        seen.payload_valid  = res_ch.payload_valid;
        seen.frame_end      = res_ch.frame_end;
        seen.status         = res_ch.status;
        seen.frame_command  = res_ch.frame_command;
        seen.command_module = res_ch.command_module;
        if (pending_results.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
                $display("unexpected result: pay=%02h v=%0d end=%0d st=%0d cmd=%02h mod=%0d",
                         seen.payload_byte, seen.payload_valid, seen.frame_end,
                         seen.status, seen.frame_command, seen.command_module);
            return;
        end
        want = pending_results.pop_front();
        if (seen.payload_byte !== want.payload_byte || seen.payload_valid !== want.payload_valid
            || seen.frame_end !== want.frame_end || seen.status !== want.status
            || seen.frame_command !== want.frame_command
            || seen.command_module !== want.command_module) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
                $write("mismatch: exp pay=%02h v=%0d end=%0d st=%0d cmd=%02h mod=%0d",
                       want.payload_byte, want.payload_valid, want.frame_end,
                       want.status, want.frame_command, want.command_module);
                $display(" got pay=%02h v=%0d end=%0d st=%0d cmd=%02h mod=%0d",
                         seen.payload_byte, seen.payload_valid, seen.frame_end,
                         seen.status, seen.frame_command, seen.command_module);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            check_result();
        take_result <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= CFG_EXPECTED_CMD;
        cfg_ch.data   <= '0;
        regs   = '0;
        fr_pos = '0;
        fr_len = '0;
        fr_chk = '0;
        fr_sum = '0;
        fr_cmd = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_byte(DIRECTED_STIM[i].rx_byte, DIRECTED_STIM[i].typed, DIRECTED_STIM[i].result);
        settle();

        for (int p = 0; p < N_PHASES; p++) begin
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 59; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 59; end
                default: begin gap_pct = 36; stall_pct = 36; end
            endcase
            reg_write(CFG_EXPECTED_CMD, PHASE_CFG[p].expected_command);
            reg_write(CFG_CHECK_CMD, {7'd0, PHASE_CFG[p].check_command});
            reg_write(CFG_ERROR_CMD, PHASE_CFG[p].error_command);
            cfg_ch.valid <= 1'b0;
            items_sent = 0;
            while (items_sent < ITEMS_PER_PHASE)
                send_frame();
            finish_frame();
            settle();
        end

        failures += pending_results.size();
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/lcpr_pkg.sv
design/lcpr_if.sv
design/lcpr_in_stage.sv
design/lcpr_deframer.sv
design/lcpr_out_stage.sv
design/length_checksum_packet_receiver.sv
design/lcpr_checker.sv
verif/length_checksum_packet_receiver_test.sv
